// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, suspended while rst_n is low.
`define SVRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising clk edge, reset included.
`define SVRT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/svrt_pkg.sv -----
// ----------------------------------------------------------------------------
// svrt_pkg
// Constants, types and header tables for the variation route tracker.
// ----------------------------------------------------------------------------
package svrt_pkg;

    localparam int unsigned PART_COUNT = 16;

    localparam logic [7:0] HDR_LEN       = 8'd6;
    localparam logic [7:0] DATA_START    = 8'd7;
    localparam logic [7:0] MIN_LAST_POS  = 8'd8;
    localparam logic [7:0] POS_MAX       = 8'hFF;
    localparam logic [8:0] ADDR_CONNECT  = 9'h05A;
    localparam logic [8:0] ADDR_PART     = 9'h05B;
    localparam logic [7:0] PART_OFF      = 8'h7F;
    localparam logic [7:0] END_BYTE      = 8'hF7;
    localparam logic [7:0] PART_LIMIT    = 8'(PART_COUNT);

    localparam logic MODE_INSERTION = 1'b0;
    localparam logic MODE_SYSTEM    = 1'b1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_CLEAR  = 2'd2
    } part_action_t;

    // Expected header byte at positions 0..5.
    function automatic logic [7:0] hdr_value(input logic [2:0] pos);
        logic [7:0] v;
        case (pos)
            3'd0:    v = 8'hF0;
            3'd1:    v = 8'h43;
            3'd2:    v = 8'h10;
            3'd3:    v = 8'h4C;
            3'd4:    v = 8'h02;
            3'd5:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Device number nibble of byte 2 is don't-care.
    function automatic logic [7:0] hdr_mask(input logic [2:0] pos);
        logic [7:0] m;
        case (pos)
            3'd2:    m = 8'hF0;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// ----- src/sysex_variation_route_tracker_core.sv -----
// ----------------------------------------------------------------------------
// sysex_variation_route_tracker_core
// Tracks variation-effect routing from XG parameter-change SysEx messages.
// ----------------------------------------------------------------------------
// Feed one SysEx byte per input transfer (kind = 0), with last_of_message set
// on the final byte, or a clear item (kind = 1) that forces insertion mode
// with no part. The header F0 43 1n 4C 02 01 is checked, byte 6 gives the
// start address, and data bytes land at rising addresses: 0x5A sets the
// connection mode (0 insertion, 1 system), 0x5B assigns a part (below
// PART_COUNT) or clears it (0x7F). These writes are held pending and commit
// only when the flagged last byte is F7, the message has at least nine bytes
// and the header matched; after the last byte the message tracking starts
// over either way. Every input transfer yields exactly one result transfer
// carrying the routing after the update and whether query_part is the
// insertion part. The whole update is one pass of logic from the input ports
// into the state and the output register, so a new item is taken every cycle
// while the output register is empty or being drained; the result is valid in
// the cycle after its input transfer.
// ----------------------------------------------------------------------------
module sysex_variation_route_tracker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic       last_of_message,
    input  logic [3:0] query_part,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       connection_mode,
    output logic       part_assigned,
    output logic [3:0] assigned_part,
    output logic       is_insertion_part
);

    // Message tracking
    logic [7:0]            byte_pos_reg,        byte_pos_next;
    logic                  header_good_reg,     header_good_next;
    logic [7:0]            start_addr_reg,      start_addr_next;
    logic                  pend_mode_valid_reg, pend_mode_valid_next;
    logic                  pend_mode_reg,       pend_mode_next;
    svrt_pkg::part_action_t pend_act_reg,       pend_act_next;
    logic [3:0]            pend_part_reg,       pend_part_next;

    // Committed routing
    logic                  mode_reg,            mode_next;
    logic                  part_valid_reg,      part_valid_next;
    logic [3:0]            part_reg,            part_next;

    // Result register
    logic                  out_valid_reg,       out_valid_next;
    logic                  res_mode_reg,        res_mode_next;
    logic                  res_assigned_reg,    res_assigned_next;
    logic [3:0]            res_part_reg,        res_part_next;
    logic                  res_ins_reg,         res_ins_next;

    logic                  in_xfer;
    logic [8:0]            data_addr;

    // Take a new item whenever the result slot is empty or drains this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Address of the current data byte; never negative past position 6.
    assign data_addr = {1'b0, start_addr_reg} + {1'b0, byte_pos_reg}
                     - {1'b0, svrt_pkg::DATA_START};

    always_comb
    begin
        byte_pos_next        = byte_pos_reg;
        header_good_next     = header_good_reg;
        start_addr_next      = start_addr_reg;
        pend_mode_valid_next = pend_mode_valid_reg;
        pend_mode_next       = pend_mode_reg;
        pend_act_next        = pend_act_reg;
        pend_part_next       = pend_part_reg;
        mode_next            = mode_reg;
        part_valid_next      = part_valid_reg;
        part_next            = part_reg;

        if (in_xfer)
        begin
            if (kind == svrt_pkg::KIND_CLEAR)
            begin
                // Reset routing only; an open message keeps its tracking.
                mode_next       = svrt_pkg::MODE_INSERTION;
                part_valid_next = 1'b0;
                part_next       = 4'd0;
            end
            else if (last_of_message)
            begin
                // Commit pending writes on a well-formed terminator.
                if (header_good_reg && data_byte == svrt_pkg::END_BYTE
                    && byte_pos_reg >= svrt_pkg::MIN_LAST_POS)
                begin
                    if (pend_mode_valid_reg)
                        mode_next = pend_mode_reg;
                    case (pend_act_reg)
                        svrt_pkg::ACT_ASSIGN:
                        begin
                            part_valid_next = 1'b1;
                            part_next       = pend_part_reg;
                        end
                        svrt_pkg::ACT_CLEAR:
                        begin
                            part_valid_next = 1'b0;
                            part_next       = 4'd0;
                        end
                        default:
                        begin
                            part_valid_next = part_valid_reg;
                        end
                    endcase
                end
                // Start over for the next message.
                byte_pos_next        = 8'd0;
                header_good_next     = 1'b1;
                start_addr_next      = 8'd0;
                pend_mode_valid_next = 1'b0;
                pend_mode_next       = 1'b0;
                pend_act_next        = svrt_pkg::ACT_NONE;
                pend_part_next       = 4'd0;
            end
            else
            begin
                if (byte_pos_reg < svrt_pkg::HDR_LEN)
                begin
                    if ((data_byte & svrt_pkg::hdr_mask(byte_pos_reg[2:0]))
                        != svrt_pkg::hdr_value(byte_pos_reg[2:0]))
                        header_good_next = 1'b0;
                end
                else if (byte_pos_reg == svrt_pkg::HDR_LEN)
                begin
                    start_addr_next = data_byte;
                end
                else if (data_addr == svrt_pkg::ADDR_CONNECT)
                begin
                    // Drop connection values above one.
                    if (data_byte <= 8'd1)
                    begin
                        pend_mode_valid_next = 1'b1;
                        pend_mode_next       = data_byte[0];
                    end
                end
                else if (data_addr == svrt_pkg::ADDR_PART)
                begin
                    if (data_byte < svrt_pkg::PART_LIMIT)
                    begin
                        pend_act_next  = svrt_pkg::ACT_ASSIGN;
                        pend_part_next = data_byte[3:0];
                    end
                    else if (data_byte == svrt_pkg::PART_OFF)
                    begin
                        pend_act_next = svrt_pkg::ACT_CLEAR;
                    end
                end
                // Advance the position, holding at the top.
                if (byte_pos_reg != svrt_pkg::POS_MAX)
                    byte_pos_next = byte_pos_reg + 8'd1;
            end
        end
    end

    // Result fields, taken from the routing after this item's update.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        res_mode_next     = res_mode_reg;
        res_assigned_next = res_assigned_reg;
        res_part_next     = res_part_reg;
        res_ins_next      = res_ins_reg;
        if (in_xfer)
        begin
            out_valid_next    = 1'b1;
            res_mode_next     = mode_next;
            res_assigned_next = part_valid_next;
            res_part_next     = part_valid_next ? part_next : 4'd0;
            res_ins_next      = (mode_next == svrt_pkg::MODE_INSERTION)
                              && part_valid_next && (query_part == part_next);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg        <= 8'd0;
            header_good_reg     <= 1'b1;
            start_addr_reg      <= 8'd0;
            pend_mode_valid_reg <= 1'b0;
            pend_mode_reg       <= 1'b0;
            pend_act_reg        <= svrt_pkg::ACT_NONE;
            pend_part_reg       <= 4'd0;
            mode_reg            <= svrt_pkg::MODE_INSERTION;
            part_valid_reg      <= 1'b0;
            part_reg            <= 4'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            byte_pos_reg        <= byte_pos_next;
            header_good_reg     <= header_good_next;
            start_addr_reg      <= start_addr_next;
            pend_mode_valid_reg <= pend_mode_valid_next;
            pend_mode_reg       <= pend_mode_next;
            pend_act_reg        <= pend_act_next;
            pend_part_reg       <= pend_part_next;
            mode_reg            <= mode_next;
            part_valid_reg      <= part_valid_next;
            part_reg            <= part_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result payload: no reset needed, qualified by out_valid.
    always_ff @(posedge clk)
    begin
        res_mode_reg     <= res_mode_next;
        res_assigned_reg <= res_assigned_next;
        res_part_reg     <= res_part_next;
        res_ins_reg      <= res_ins_next;
    end

    assign out_valid         = out_valid_reg;
    assign connection_mode   = res_mode_reg;
    assign part_assigned     = res_assigned_reg;
    assign assigned_part     = res_part_reg;
    assign is_insertion_part = res_ins_reg;

endmodule

// ----- src/svrt_checker.sv -----
// ----------------------------------------------------------------------------
// svrt_checker
// Port-level checks for the variation route tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svrt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic       connection_mode,
    input logic       part_assigned,
    input logic [3:0] assigned_part,
    input logic       is_insertion_part
);

    // An unassigned part always reads as zero.
    `SVRT_ASSERT(a_part_zero, out_valid && !part_assigned |-> assigned_part == 4'd0, "assigned_part not zero without assignment")

    // The insertion flag needs insertion mode and an assigned part.
    `SVRT_ASSERT_ALWAYS(a_ins_cons, out_valid && is_insertion_part |-> connection_mode == svrt_pkg::MODE_INSERTION && part_assigned, "is_insertion_part inconsistent with routing")

    // A clear item shows defaults in its result on the next cycle.
    `SVRT_ASSERT(a_clear_result, in_valid && in_ready && kind == svrt_pkg::KIND_CLEAR |=> out_valid && connection_mode == svrt_pkg::MODE_INSERTION && !part_assigned, "clear item did not give default routing")

    // A stalled result holds its payload.
    `SVRT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(connection_mode) && $stable(part_assigned) && $stable(assigned_part) && $stable(is_insertion_part), "stalled result changed")

endmodule

bind sysex_variation_route_tracker_core svrt_checker u_svrt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .connection_mode   (connection_mode),
    .part_assigned     (part_assigned),
    .assigned_part     (assigned_part),
    .is_insertion_part (is_insertion_part)
);
